### sv/tetrahedron_volume_insphere_defines.svh
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TETRAHEDRON_VOLUME_INSPHERE_DEFINES_SVH
`define TETRAHEDRON_VOLUME_INSPHERE_DEFINES_SVH
`ifndef SYNTHESIS
`define TVI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tvi assertion failed");
`define TVI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tvi assertion failed");
`else
`define TVI_ASSERT_IMP(label, ante, cons)
`define TVI_ASSERT_NXT(label, ante, cons)
`endif
`endif

### sv/tvi_pkg.sv
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: package
// Fixed formats, result widths and the control group passed along the chain.
// ----------------------------------------------------------------------------
package tvi_pkg;

  localparam int CoordWidth = 16;
  localparam int FracBits   = 8;
  localparam int VolFrac    = 24;
  localparam int RadFrac    = 16;
  localparam int VolWidth   = 49;
  localparam int RadWidth   = 24;

  typedef struct packed {
    logic valid;
    logic degen;
    logic rsat;
  } tvi_ctl_t;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/tvi_if.sv
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: channel interfaces
// Valid/ready channels for the vertex input and the result output.
// ----------------------------------------------------------------------------
interface tvi_in_if #(
  parameter int COORD_WIDTH = tvi_pkg::CoordWidth
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
                  input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz,
                  output ready);
endinterface

interface tvi_out_if;
  logic                            valid;
  logic                            ready;
  logic [tvi_pkg::VolWidth-1:0]    volume;
  logic [tvi_pkg::RadWidth-1:0]    radius;
  logic                            degenerate;

  modport source (output valid, volume, radius, degenerate, input ready);
  modport sink   (input valid, volume, radius, degenerate, output ready);
endinterface

### sv/tetrahedron_volume_insphere.sv
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: top level
// Takes one tetrahedron per cycle while the chain is not held, and returns |det|/6 and the insphere radius.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the chain is not held; each result
// passes through four front-end stages, one square-root cell per root bit, one
// norm-sum stage, 24 divider cells (one radius quotient bit each) and the output
// register. The whole chain advances together, so it holds while a finished
// result is not taken. No reset sweep.
module tetrahedron_volume_insphere #(
  parameter int COORD_WIDTH = tvi_pkg::CoordWidth,
  parameter int FRAC_BITS   = tvi_pkg::FracBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvi_in_if.sink     in_i,
  tvi_out_if.source  out_o
);
  `include "tetrahedron_volume_insphere_defines.svh"

  localparam int DW   = COORD_WIDTH + 1;
  localparam int XW   = 2 * DW + 1;
  localparam int PW   = DW + XW;
  localparam int ADW  = PW + 2;
  localparam int SQW  = 2 * XW + 2;
  localparam int RW   = XW + 1;
  localparam int NSW  = RW + 2;
  localparam int NC   = tvi_pkg::RadWidth;
  localparam int RSH  = tvi_pkg::RadFrac - FRAC_BITS;
  localparam int RN   = ADW + RSH;
  localparam int RMW  = tvi_pkg::max_int(RN, NSW + NC);
  localparam int VNW  = ADW + tvi_pkg::VolFrac;
  localparam int VPC  = (VNW + NC - 1) / NC;
  localparam int VPAD = VPC * NC;
  localparam int VSH  = 3 * FRAC_BITS + 1;
  localparam int VW   = tvi_pkg::VolWidth;

  logic                         en;
  logic [11:0][COORD_WIDTH-1:0] coord;

  tvi_pkg::tvi_ctl_t            s_ctl[RW+1];
  logic [3:0][SQW-1:0]          s_rem[RW+1];
  logic [3:0][RW-1:0]           s_root[RW+1];
  logic [ADW-1:0]               s_det[RW+1];

  logic [NSW-1:0]               ns;
  logic [RMW-1:0]               rn;
  logic [VNW-1:0]               vext;

  tvi_pkg::tvi_ctl_t            d_ctl[NC+1];
  logic [RMW-1:0]               d_rrem[NC+1];
  logic [NSW-1:0]               d_ns[NC+1];
  logic [NC-1:0]                d_rq[NC+1];
  logic [VPAD-1:0]              d_vv[NC+1];
  logic [1:0]                   d_vr[NC+1];

  tvi_pkg::tvi_ctl_t            e_ctl_q;
  logic [RMW-1:0]               e_rrem_q;
  logic [NSW-1:0]               e_ns_q;
  logic [VPAD-1:0]              e_vv_q;

  logic                         out_valid_q;
  logic [VW-1:0]                volume_q;
  logic [NC-1:0]                radius_q;
  logic                         degen_q;

  assign en = !out_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign coord = {in_i.dz, in_i.dy, in_i.dx, in_i.cz, in_i.cy, in_i.cx,
                  in_i.bz, in_i.by, in_i.bx, in_i.az, in_i.ay, in_i.ax};

  tvi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .coord_i  (coord),
    .ctl_o    (s_ctl[0]),
    .absdet_o (s_det[0]),
    .sq_o     (s_rem[0])
  );
  assign s_root[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    tvi_sqrt_cell #(.SQW(SQW), .RW(RW), .ADW(ADW), .BIT(RW - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (s_ctl[i]),
      .rem_i  (s_rem[i]),
      .root_i (s_root[i]),
      .det_i  (s_det[i]),
      .ctl_o  (s_ctl[i+1]),
      .rem_o  (s_rem[i+1]),
      .root_o (s_root[i+1]),
      .det_o  (s_det[i+1])
    );
  end

  assign ns   = NSW'(s_root[RW][0]) + NSW'(s_root[RW][1])
              + NSW'(s_root[RW][2]) + NSW'(s_root[RW][3]);
  assign rn   = RMW'(s_det[RW]) << RSH;
  assign vext = {s_det[RW], {tvi_pkg::VolFrac{1'b0}}} >> VSH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_ctl_q <= '0;
    end else if (en) begin
      e_ctl_q <= '{valid: s_ctl[RW].valid,
                   degen: ns == '0,
                   rsat:  rn >= (RMW'(ns) << NC)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_rrem_q <= rn;
      e_ns_q   <= ns;
      e_vv_q   <= VPAD'(vext);
    end
  end

  assign d_ctl[0]  = e_ctl_q;
  assign d_rrem[0] = e_rrem_q;
  assign d_ns[0]   = e_ns_q;
  assign d_rq[0]   = '0;
  assign d_vv[0]   = e_vv_q;
  assign d_vr[0]   = '0;

  for (genvar i = 0; i < NC; i++) begin : g_div
    tvi_div_cell #(.RMW(RMW), .NSW(NSW), .VPC(VPC), .BIT(NC - 1 - i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (d_ctl[i]),
      .rrem_i (d_rrem[i]),
      .ns_i   (d_ns[i]),
      .rq_i   (d_rq[i]),
      .vv_i   (d_vv[i]),
      .vr_i   (d_vr[i]),
      .ctl_o  (d_ctl[i+1]),
      .rrem_o (d_rrem[i+1]),
      .ns_o   (d_ns[i+1]),
      .rq_o   (d_rq[i+1]),
      .vv_o   (d_vv[i+1]),
      .vr_o   (d_vr[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_ctl[NC].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      volume_q <= (|d_vv[NC][VPAD-1:VW]) ? {VW{1'b1}} : d_vv[NC][VW-1:0];
      radius_q <= d_ctl[NC].degen ? '0 : (d_ctl[NC].rsat ? {NC{1'b1}} : d_rq[NC]);
      degen_q  <= d_ctl[NC].degen;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.volume     = volume_q;
  assign out_o.radius     = radius_q;
  assign out_o.degenerate = degen_q;

  `TVI_ASSERT_IMP(a_degen_radius, out_o.valid && out_o.degenerate, out_o.radius == '0)
  `TVI_ASSERT_IMP(a_degen_volume, out_o.valid && out_o.degenerate, out_o.volume == '0)
  `TVI_ASSERT_IMP(a_stall_blocks_in, out_o.valid && !out_o.ready, !in_i.ready)
  `TVI_ASSERT_NXT(a_stall_keeps_out, out_o.valid && !out_o.ready, out_o.valid)

endmodule

### sv/tvi_front.sv
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: front end
// Edge vectors, face cross products, |det| and the squared face norms,
// four register stages.
// ----------------------------------------------------------------------------
module tvi_front #(
  parameter int COORD_WIDTH = tvi_pkg::CoordWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [11:0][COORD_WIDTH-1:0]      coord_i,
  output tvi_pkg::tvi_ctl_t                 ctl_o,
  output logic [3*COORD_WIDTH+5:0]          absdet_o,
  output logic [3:0][4*COORD_WIDTH+7:0]     sq_o
);
  localparam int DW  = COORD_WIDTH + 1;
  localparam int XW  = 2 * DW + 1;
  localparam int PW  = DW + XW;
  localparam int ADW = PW + 2;
  localparam int SQW = 2 * XW + 2;

  logic signed [COORD_WIDTH-1:0] crd[4][3];
  logic signed [DW-1:0] ab_q[3], ac_q[3], ad_q[3], bc_q[3], bd_q[3];
  logic signed [DW-1:0] fu[4][3], fv[4][3];
  logic signed [XW-1:0] xf_q[4][3];
  logic signed [DW-1:0] abb_q[3];
  logic signed [PW-1:0] detp_q[3];
  logic [XW-1:0]        mg[4][3];
  logic [2*XW-1:0]      sqp_q[4][3];
  logic signed [ADW-1:0] det;
  logic [ADW-1:0]       absdet_q;
  logic [3:0][SQW-1:0]  sq_q;
  logic [3:0]           v_q;

  for (genvar i = 0; i < 4; i++) begin : g_crd
    for (genvar j = 0; j < 3; j++) begin : g_c
      assign crd[i][j] = coord_i[i*3+j];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_face
    assign fu[0][j] = ab_q[j]; assign fv[0][j] = ac_q[j];
    assign fu[1][j] = ab_q[j]; assign fv[1][j] = ad_q[j];
    assign fu[2][j] = ac_q[j]; assign fv[2][j] = ad_q[j];
    assign fu[3][j] = bc_q[j]; assign fv[3][j] = bd_q[j];
  end

  for (genvar f = 0; f < 4; f++) begin : g_mag
    for (genvar j = 0; j < 3; j++) begin : g_m
      assign mg[f][j] = xf_q[f][j][XW-1] ? XW'(-xf_q[f][j]) : XW'(xf_q[f][j]);
    end
  end

  assign det = ADW'(detp_q[0]) + ADW'(detp_q[1]) + ADW'(detp_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        ab_q[j] <= DW'(crd[1][j]) - DW'(crd[0][j]);
        ac_q[j] <= DW'(crd[2][j]) - DW'(crd[0][j]);
        ad_q[j] <= DW'(crd[3][j]) - DW'(crd[0][j]);
        bc_q[j] <= DW'(crd[2][j]) - DW'(crd[1][j]);
        bd_q[j] <= DW'(crd[3][j]) - DW'(crd[1][j]);
        abb_q[j] <= ab_q[j];
        detp_q[j] <= PW'(abb_q[j]) * PW'(xf_q[2][j]);
      end
      for (int f = 0; f < 4; f++) begin
        for (int j = 0; j < 3; j++) begin
          xf_q[f][j] <= XW'(fu[f][(j+1)%3] * fv[f][(j+2)%3])
                      - XW'(fu[f][(j+2)%3] * fv[f][(j+1)%3]);
          sqp_q[f][j] <= (2*XW)'(mg[f][j]) * (2*XW)'(mg[f][j]);
        end
        sq_q[f] <= SQW'(sqp_q[f][0]) + SQW'(sqp_q[f][1]) + SQW'(sqp_q[f][2]);
      end
      absdet_q <= det[ADW-1] ? ADW'(-det) : ADW'(det);
    end
  end

  assign ctl_o    = '{valid: v_q[3], degen: 1'b0, rsat: 1'b0};
  assign absdet_o = absdet_q;
  assign sq_o     = sq_q;

endmodule

### sv/tvi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: square-root cell
// Settles one root bit of each of the four face norms and passes |det| on.
// ----------------------------------------------------------------------------
module tvi_sqrt_cell #(
  parameter int SQW = 72,
  parameter int RW  = 36,
  parameter int ADW = 54,
  parameter int BIT = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  tvi_pkg::tvi_ctl_t      ctl_i,
  input  logic [3:0][SQW-1:0]    rem_i,
  input  logic [3:0][RW-1:0]     root_i,
  input  logic [ADW-1:0]         det_i,
  output tvi_pkg::tvi_ctl_t      ctl_o,
  output logic [3:0][SQW-1:0]    rem_o,
  output logic [3:0][RW-1:0]     root_o,
  output logic [ADW-1:0]         det_o
);
  logic [3:0][SQW:0]    trial;
  logic [3:0]           take;
  logic [3:0][SQW-1:0]  rem_d;
  logic [3:0][RW-1:0]   root_d;
  tvi_pkg::tvi_ctl_t    ctl_q;
  logic [3:0][SQW-1:0]  rem_q;
  logic [3:0][RW-1:0]   root_q;
  logic [ADW-1:0]       det_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial[l] = ((SQW+1)'(root_i[l]) << (BIT + 1)) | ((SQW+1)'(1) << (2 * BIT));
      take[l]  = (SQW+1)'(rem_i[l]) >= trial[l];
      rem_d[l] = take[l] ? SQW'((SQW+1)'(rem_i[l]) - trial[l]) : rem_i[l];
      root_d[l] = root_i[l];
      root_d[l][BIT] = take[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      det_q  <= det_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign det_o  = det_q;

endmodule

### sv/tvi_div_cell.sv
// ----------------------------------------------------------------------------
// Tetrahedron volume / insphere radius: divider cell
// One restoring step of the radius quotient and one digit group of the
// volume division by three.
// ----------------------------------------------------------------------------
module tvi_div_cell #(
  parameter int RMW = 88,
  parameter int NSW = 38,
  parameter int VPC = 4,
  parameter int BIT = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  tvi_pkg::tvi_ctl_t                         ctl_i,
  input  logic [RMW-1:0]                            rrem_i,
  input  logic [NSW-1:0]                            ns_i,
  input  logic [tvi_pkg::RadWidth-1:0]              rq_i,
  input  logic [VPC*tvi_pkg::RadWidth-1:0]          vv_i,
  input  logic [1:0]                                vr_i,
  output tvi_pkg::tvi_ctl_t                         ctl_o,
  output logic [RMW-1:0]                            rrem_o,
  output logic [NSW-1:0]                            ns_o,
  output logic [tvi_pkg::RadWidth-1:0]              rq_o,
  output logic [VPC*tvi_pkg::RadWidth-1:0]          vv_o,
  output logic [1:0]                                vr_o
);
  localparam int VPAD = VPC * tvi_pkg::RadWidth;

  logic [RMW-1:0]                 den;
  logic                           ge;
  logic [RMW-1:0]                 rrem_d;
  logic [tvi_pkg::RadWidth-1:0]   rq_d;
  logic [VPAD-1:0]                vv_d;
  logic [1:0]                     vr_d;
  logic [2:0]                     t;
  tvi_pkg::tvi_ctl_t              ctl_q;
  logic [RMW-1:0]                 rrem_q;
  logic [NSW-1:0]                 ns_q;
  logic [tvi_pkg::RadWidth-1:0]   rq_q;
  logic [VPAD-1:0]                vv_q;
  logic [1:0]                     vr_q;

  assign den    = RMW'(ns_i) << BIT;
  assign ge     = rrem_i >= den;
  assign rrem_d = ge ? rrem_i - den : rrem_i;

  always_comb begin
    rq_d      = rq_i;
    rq_d[BIT] = ge;
    vv_d      = vv_i;
    vr_d      = vr_i;
    t         = '0;
    for (int i = VPC - 1; i >= 0; i--) begin
      t = {vr_d, vv_i[BIT*VPC+i]};
      if (t >= 3'd3) begin
        vr_d = 2'(t - 3'd3);
        vv_d[BIT*VPC+i] = 1'b1;
      end else begin
        vr_d = t[1:0];
        vv_d[BIT*VPC+i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rrem_q <= rrem_d;
      ns_q   <= ns_i;
      rq_q   <= rq_d;
      vv_q   <= vv_d;
      vr_q   <= vr_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign rrem_o = rrem_q;
  assign ns_o   = ns_q;
  assign rq_o   = rq_q;
  assign vv_o   = vv_q;
  assign vr_o   = vr_q;

endmodule
